// ===== rtl/psc_pkg.sv =====
`default_nettype none

package psc_pkg;

	localparam int WINDOW_BYTES   = 4096;
	localparam int MAX_MIN_LENGTH = 16;

	localparam int OFF_W       = $clog2(WINDOW_BYTES) + 1;
	localparam int CNT_W       = 13;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int HELD_AW     = $clog2(MAX_MIN_LENGTH);
	localparam int CHAR_W      = 7;
	localparam int BYTE_W      = 8;
	localparam int MINLEN_W    = 5;
	localparam int ADDR_W      = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 72;

	localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

	localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = 5'd5;

	localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
	localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic               flush;
		logic [HELD_AW-1:0] flush_last;
		logic               chr;
		logic [CHAR_W-1:0]  ch;
		logic               marker;
		logic [OFF_W-1:0]   start;
	} psc_job_t;

endpackage

`default_nettype wire

// ===== rtl/psc_held_ram.sv =====
`default_nettype none

module psc_held_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [psc_pkg::HELD_AW-1:0] waddr,
	input  wire logic [psc_pkg::CHAR_W-1:0]  wdata,
	input  wire logic [psc_pkg::HELD_AW-1:0] raddr,
	output logic      [psc_pkg::CHAR_W-1:0]  rdata
);

	logic [psc_pkg::CHAR_W-1:0] mem [psc_pkg::MAX_MIN_LENGTH];
	logic [psc_pkg::CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// write-first on a same-entry collision
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/psc_scan.sv =====
`default_nettype none

module psc_scan (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [psc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_accept,
	input  wire logic [psc_pkg::BYTE_W-1:0]     unit_low,
	input  wire logic                           end_of_region,
	output logic                                job_valid,
	output psc_pkg::psc_job_t                   job,
	output logic                                held_we,
	output logic      [psc_pkg::HELD_AW-1:0]    held_waddr,
	output logic      [psc_pkg::CHAR_W-1:0]     held_wdata,
	output logic      [psc_pkg::ADDR_W-1:0]     base_address
);

	logic                          wide_q;
	logic [psc_pkg::MINLEN_W-1:0]  min_len_q;
	logic [psc_pkg::ADDR_W-1:0]    base_q;

	logic [psc_pkg::CNT_W-1:0]     run_count_q;
	logic [psc_pkg::OFF_W-1:0]     run_start_q;
	logic [psc_pkg::OFF_W-1:0]     off_q;
	logic                          win_done_q;

	logic [psc_pkg::CNT_W-1:0]     ml;
	logic [psc_pkg::CNT_W-1:0]     thr;
	logic [psc_pkg::CNT_W-1:0]     cnt_inc;
	logic [psc_pkg::CNT_W-1:0]     c1;
	logic [psc_pkg::OFF_W-1:0]     start1;
	logic [psc_pkg::OFF_W-1:0]     off2;
	logic [psc_pkg::OFF_W-1:0]     step;
	logic                          win2;
	logic                          printable;
	logic                          active;
	logic                          marker;
	logic                          do_flush;
	logic                          do_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q    <= 1'b0;
			min_len_q <= psc_pkg::MIN_LENGTH_RESET;
			base_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psc_pkg::REG_WIDE_MODE:    wide_q    <= cfg_data[0];
				psc_pkg::REG_MIN_LENGTH:   min_len_q <= cfg_data[psc_pkg::MINLEN_W-1:0];
				psc_pkg::REG_BASE_ADDRESS: base_q    <= cfg_data[psc_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ml        = psc_pkg::CNT_W'(min_len_q);
		thr       = ml;
		if (ml == '0) begin
			thr = psc_pkg::CNT_W'(1);
		end else if (ml > psc_pkg::CNT_W'(psc_pkg::MAX_MIN_LENGTH)) begin
			thr = psc_pkg::CNT_W'(psc_pkg::MAX_MIN_LENGTH);
		end

		printable = (unit_low >= psc_pkg::PRINT_LO) && (unit_low <= psc_pkg::PRINT_HI);
		active    = !win_done_q && (off_q < psc_pkg::OFF_W'(psc_pkg::WINDOW_BYTES));
		step      = wide_q ? psc_pkg::OFF_W'(2) : psc_pkg::OFF_W'(1);
		cnt_inc   = (run_count_q != psc_pkg::CNT_MAX) ? run_count_q + psc_pkg::CNT_W'(1)
		                                               : run_count_q;

		c1       = run_count_q;
		start1   = run_start_q;
		off2     = off_q;
		win2     = win_done_q;
		marker   = 1'b0;
		do_flush = 1'b0;
		do_char  = 1'b0;

		if (active) begin
			if (printable) begin
				if (run_count_q == '0) begin
					start1 = off_q;
				end
				c1       = cnt_inc;
				do_flush = (run_count_q < thr) && (cnt_inc == thr);
				do_char  = (run_count_q >= thr);
			end else begin
				marker = (run_count_q >= thr);
				c1     = '0;
			end
			off2 = off_q + step;
			// window full closes the run
			if (off2 >= psc_pkg::OFF_W'(psc_pkg::WINDOW_BYTES)) begin
				if (c1 >= thr) begin
					marker = 1'b1;
				end
				c1   = '0;
				win2 = 1'b1;
			end
		end

		if (end_of_region) begin
			if (c1 >= thr) begin
				marker = 1'b1;
			end
			c1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			run_start_q <= '0;
			off_q       <= '0;
			win_done_q  <= 1'b0;
		end else if (in_accept) begin
			run_count_q <= c1;
			run_start_q <= end_of_region ? '0 : start1;
			off_q       <= end_of_region ? '0 : off2;
			win_done_q  <= end_of_region ? 1'b0 : win2;
		end
	end

	assign job_valid       = in_accept && (do_flush || do_char || marker);
	assign job.flush       = do_flush;
	assign job.flush_last  = psc_pkg::HELD_AW'(thr - psc_pkg::CNT_W'(1));
	assign job.chr         = do_char;
	assign job.ch          = unit_low[psc_pkg::CHAR_W-1:0];
	assign job.marker      = marker;
	assign job.start       = start1;

	assign held_we    = in_accept && active && printable &&
	                    (run_count_q < psc_pkg::CNT_W'(psc_pkg::MAX_MIN_LENGTH));
	assign held_waddr = run_count_q[psc_pkg::HELD_AW-1:0];
	assign held_wdata = unit_low[psc_pkg::CHAR_W-1:0];

	assign base_address = base_q;

endmodule

`default_nettype wire

// ===== rtl/psc_emit.sv =====
`default_nettype none

module psc_emit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            job_valid,
	input  wire psc_pkg::psc_job_t               job,
	output logic                                 job_ready,
	output logic      [psc_pkg::HELD_AW-1:0]     rd_addr,
	input  wire logic [psc_pkg::CHAR_W-1:0]      rd_data,
	input  wire logic [psc_pkg::ADDR_W-1:0]      base_address,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic      [psc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast
);

	logic                          busy_s1;
	logic                          fl_s1;
	logic [psc_pkg::HELD_AW-1:0]   idx_s1;
	logic [psc_pkg::HELD_AW-1:0]   flast_s1;
	logic                          chp_s1;
	logic [psc_pkg::CHAR_W-1:0]    ch_s1;
	logic                          mk_s1;
	logic [psc_pkg::OFF_W-1:0]     start_s1;

	logic                            out_valid_q;
	logic [psc_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                            out_kind_q;
	logic                            out_last_q;
	logic                            skid_valid_q;
	logic [psc_pkg::OUT_TDATA_W-1:0] skid_data_q;
	logic                            skid_kind_q;
	logic                            skid_last_q;

	logic                            push;
	logic                            done;
	logic                            load;
	logic                            flush_end;
	logic                            out_free;
	logic [psc_pkg::CHAR_W-1:0]      beat_char;
	logic                            beat_kind;
	logic                            beat_last;
	logic [psc_pkg::ADDR_W-1:0]      beat_addr;
	logic [psc_pkg::OUT_TDATA_W-1:0] beat_data;

	always_comb begin
		beat_char = '0;
		beat_kind = psc_pkg::KIND_END;
		beat_last = 1'b1;
		priority if (fl_s1) begin
			beat_char = rd_data;
			beat_kind = psc_pkg::KIND_CHAR;
			beat_last = (idx_s1 == flast_s1) && !chp_s1 && !mk_s1;
		end else if (chp_s1) begin
			beat_char = ch_s1;
			beat_kind = psc_pkg::KIND_CHAR;
			beat_last = !mk_s1;
		end else begin
			beat_char = '0;
		end
	end

	assign flush_end = (idx_s1 == flast_s1);
	assign push      = busy_s1 && !skid_valid_q;
	assign done      = push && beat_last;
	assign job_ready = !busy_s1 || done;
	assign load      = job_valid && job_ready;

	// address for the beat after this one, so the ram data lines up
	always_comb begin
		if (load) begin
			rd_addr = '0;
		end else if (push && fl_s1 && !flush_end) begin
			rd_addr = idx_s1 + psc_pkg::HELD_AW'(1);
		end else begin
			rd_addr = idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			fl_s1   <= 1'b0;
			idx_s1  <= '0;
			chp_s1  <= 1'b0;
			mk_s1   <= 1'b0;
		end else if (load) begin
			busy_s1 <= 1'b1;
			fl_s1   <= job.flush;
			idx_s1  <= '0;
			chp_s1  <= job.chr;
			mk_s1   <= job.marker;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end else if (push) begin
			priority if (fl_s1) begin
				if (flush_end) begin
					fl_s1 <= 1'b0;
				end else begin
					idx_s1 <= idx_s1 + psc_pkg::HELD_AW'(1);
				end
			end else if (chp_s1) begin
				chp_s1 <= 1'b0;
			end else begin
				mk_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			flast_s1 <= job.flush_last;
			ch_s1    <= job.ch;
			start_s1 <= job.start;
		end
	end

	assign beat_addr = base_address + psc_pkg::ADDR_W'(start_s1);
	assign beat_data = {{(psc_pkg::OUT_TDATA_W - psc_pkg::ADDR_W - psc_pkg::CHAR_W){1'b0}},
	                    beat_addr, beat_char};

	// output register plus skid entry
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				out_kind_q <= skid_kind_q;
				out_last_q <= skid_last_q;
			end else begin
				out_data_q <= beat_data;
				out_kind_q <= beat_kind;
				out_last_q <= beat_last;
			end
		end else if (push) begin
			skid_data_q <= beat_data;
			skid_kind_q <= beat_kind;
			skid_last_q <= beat_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/printable_string_carver.sv =====
`default_nettype none

// Carves runs of printable characters (0x20..0x7E) out of a byte or UTF-16 stream and
// sends them as character beats tagged with the run's start address, each reported
// run closed by an end beat. An input beat that yields at most one result is taken
// every cycle while the output is not stalled; one that yields more holds the input
// until the output sequencer has sent them all, one beat a cycle while the output is
// not stalled. When a run reaches min_length, its held characters are read back from
// a 16-entry held-character RAM, one entry per beat, followed by an end beat if that
// input also closes the run. A two-entry output stage decouples m_axis_tready from
// s_axis_tready. There is no clearing pass after reset.
module printable_string_carver (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [psc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // unit_low, unit_high
	input  wire logic                            s_axis_tlast,  // end_of_region
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic      [psc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // char_value, string_address
	output logic                                 m_axis_tuser,  // item_kind
	output logic                                 m_axis_tlast   // last beat for its input
);

	logic                          in_accept;
	logic                          job_valid;
	logic                          job_ready;
	psc_pkg::psc_job_t             job;
	logic                          held_we;
	logic [psc_pkg::HELD_AW-1:0]   held_waddr;
	logic [psc_pkg::CHAR_W-1:0]    held_wdata;
	logic [psc_pkg::HELD_AW-1:0]   held_raddr;
	logic [psc_pkg::CHAR_W-1:0]    held_rdata;
	logic [psc_pkg::ADDR_W-1:0]    base_address;

	assign s_axis_tready = job_ready;
	assign in_accept     = s_axis_tvalid && job_ready;

	psc_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_accept     (in_accept),
		.unit_low      (s_axis_tdata[psc_pkg::BYTE_W-1:0]),
		.end_of_region (s_axis_tlast),
		.job_valid     (job_valid),
		.job           (job),
		.held_we       (held_we),
		.held_waddr    (held_waddr),
		.held_wdata    (held_wdata),
		.base_address  (base_address)
	);

	psc_held_ram u_held_ram (
		.clk   (clk),
		.we    (held_we),
		.waddr (held_waddr),
		.wdata (held_wdata),
		.raddr (held_raddr),
		.rdata (held_rdata)
	);

	psc_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job           (job),
		.job_ready     (job_ready),
		.rd_addr       (held_raddr),
		.rd_data       (held_rdata),
		.base_address  (base_address),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/psc_checker.sv =====
`default_nettype none

module psc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [psc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                            m_axis_tuser,
	input wire logic                            m_axis_tlast
);

	a_no_beat_in_reset: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("output beat during reset");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("stalled output beat changed");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == psc_pkg::KIND_END) |-> m_axis_tlast)
		else $error("end of string beat not last of its input");

	a_end_zero_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == psc_pkg::KIND_END) |->
			(m_axis_tdata[psc_pkg::CHAR_W-1:0] == '0))
		else $error("end of string beat carries a character");

	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == psc_pkg::KIND_CHAR) |->
			(m_axis_tdata[psc_pkg::CHAR_W-1:0] >= 7'h20) &&
			(m_axis_tdata[psc_pkg::CHAR_W-1:0] != 7'h7F))
		else $error("character beat not printable");

endmodule

bind printable_string_carver psc_checker u_psc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
